[hw/rtl/grid_path_count_exact_sum_defines.svh]
// Assertion macros shared by the checker of grid_path_count_exact_sum.
// No dependencies; clocked on i_clk, GPCES_ASSERT qualified by the active-low i_rst_n.
`ifndef GRID_PATH_COUNT_EXACT_SUM_DEFINES_SVH
`define GRID_PATH_COUNT_EXACT_SUM_DEFINES_SVH

// checked outside reset only
`define GPCES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GPCES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/gpces_pkg.sv]
// Shared constants and types for the exact-sum grid path counter.
// No dependencies.
package gpces_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int MAX_SUM  = 255;
    localparam int COUNT_W  = 32;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int SUM_W      = $clog2(MAX_SUM + 1);
    localparam int LINE_AW    = COL_W + SUM_W;
    localparam int LINE_DEPTH = MAX_COLS * (2 ** SUM_W);

    localparam int COIN_W     = 8;
    localparam int VAL_W      = COIN_W - 1;
    localparam int TARGET_W   = 8;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_DATA_W = 40;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_COLS   = 2'd2
    } t_cfg_idx;

    // one classified cell handed from front to back
    typedef struct packed {
        logic             first;  // top-left cell
        logic             up;     // row above exists
        logic             left;   // column to the left exists
        logic             last;   // bottom-right cell, result follows
        logic             dead;   // blocked or coin above target
        logic [VAL_W-1:0] val;    // coin magnitude
        logic [COL_W-1:0] col;
    } t_cell_cmd;

endpackage

[hw/rtl/gpces_ram.sv]
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module gpces_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[hw/rtl/gpces_queue.sv]
// Short command queue between the cell classifier and the count engine.
// Depends on gpces_pkg.
module gpces_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gpces_pkg::t_cell_cmd i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output gpces_pkg::t_cell_cmd o_data,
    input  logic                 i_pop
);

    localparam int PTR_W = $clog2(gpces_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gpces_pkg::QUEUE_DEPTH + 1);

    gpces_pkg::t_cell_cmd r_slot [gpces_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(gpces_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(gpces_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/gpces_front.sv]
// Front end: takes coin items, tracks the grid position, classifies each cell.
// Depends on gpces_pkg.
module gpces_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [gpces_pkg::ROW_W-1:0]       i_rows_m1,
    input  logic [gpces_pkg::COL_W-1:0]       i_cols_m1,
    input  logic [gpces_pkg::TARGET_W-1:0]    i_target,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic [gpces_pkg::COIN_W-1:0]      i_tdata,
    input  logic                              i_q_full,
    output logic                              o_push,
    output gpces_pkg::t_cell_cmd              o_cmd
);

    logic [gpces_pkg::ROW_W-1:0] r_row;
    logic [gpces_pkg::COL_W-1:0] r_col;
    logic [gpces_pkg::ROW_W-1:0] n_row;
    logic [gpces_pkg::COL_W-1:0] n_col;
    logic                        row_end;

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;
    assign row_end  = (r_col == i_cols_m1);

    always_comb begin
        o_cmd.first = (r_row == '0) && (r_col == '0);
        o_cmd.up    = (r_row != '0);
        o_cmd.left  = (r_col != '0);
        o_cmd.last  = (r_row == i_rows_m1) && row_end;
        o_cmd.val   = i_tdata[gpces_pkg::VAL_W-1:0];
        // sign bit marks a blocked cell
        o_cmd.dead  = i_tdata[gpces_pkg::COIN_W-1]
                   || ({1'b0, i_tdata[gpces_pkg::VAL_W-1:0]} > i_target);
        o_cmd.col   = r_col;
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (o_cmd.last) begin
            n_row = '0;
            n_col = '0;
        end else if (row_end) begin
            n_row = r_row + 1'b1;
            n_col = '0;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

[hw/rtl/gpces_back.sv]
// Back end: per cell, sweeps partial sums target..0 through the count line store.
// Depends on gpces_pkg and gpces_ram.
module gpces_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [gpces_pkg::TARGET_W-1:0]    i_target,
    input  logic                              i_cmd_valid,
    input  gpces_pkg::t_cell_cmd              i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [gpces_pkg::COUNT_W-1:0]     o_path_count,
    output logic                              o_count_ovf
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_back_state;

    localparam int SW = gpces_pkg::SUM_W;
    localparam int CW = gpces_pkg::COUNT_W;

    t_back_state           r_state, n_state;
    gpces_pkg::t_cell_cmd  r_cmd, n_cmd;
    logic [SW-1:0]         r_rd_s, n_rd_s;
    logic                  r_p_valid, n_p_valid;
    logic [SW-1:0]         r_p_s, n_p_s;
    logic [CW-1:0]         r_total, n_total;
    logic                  r_ovf, n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic [CW-1:0]         r_out_count, n_out_count;
    logic                  r_out_ovf, n_out_ovf;

    logic [SW-1:0]                   from_s;
    logic [gpces_pkg::LINE_AW-1:0]   ra_up, ra_left, wa;
    logic [CW-1:0]                   rd_up, rd_left;
    logic [CW-1:0]                   term_up, term_left, cell_val;
    logic [CW:0]                     sum_w;
    logic                            live, sat_ev, out_free, emit;

    assign from_s  = r_rd_s - SW'(r_cmd.val);
    assign ra_up   = {r_cmd.col, from_s};
    assign ra_left = {r_cmd.col - 1'b1, from_s};
    assign wa      = {r_cmd.col, r_p_s};

    gpces_ram #(
        .WIDTH (CW),
        .DEPTH (gpces_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_we      (r_p_valid),
        .i_waddr   (wa),
        .i_wdata   (cell_val),
        .i_re      (r_state == ST_RUN),
        .i_raddr_a (ra_up),
        .i_raddr_b (ra_left),
        .o_rdata_a (rd_up),
        .o_rdata_b (rd_left)
    );

    // count for partial sum r_p_s: zero unless live, start cell seeds, else above + left, saturating
    always_comb begin
        live      = !r_cmd.dead && (r_p_s >= SW'(r_cmd.val));
        term_up   = r_cmd.up ? rd_up : '0;
        term_left = r_cmd.left ? rd_left : '0;
        sum_w     = {1'b0, term_up} + {1'b0, term_left};
        sat_ev    = r_p_valid && live && !r_cmd.first && sum_w[CW];
        if (!live) begin
            cell_val = '0;
        end else if (r_cmd.first) begin
            cell_val = CW'(r_p_s == SW'(r_cmd.val));
        end else if (sum_w[CW]) begin
            cell_val = '1;
        end else begin
            cell_val = sum_w[CW-1:0];
        end
    end

    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rd_s      = r_rd_s;
        n_p_valid   = r_p_valid;
        n_p_s       = r_p_s;
        n_total     = (r_p_valid && (r_p_s == i_target)) ? cell_val : r_total;
        n_ovf       = r_ovf || sat_ev;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        o_cmd_pop   = 1'b0;
        emit        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_rd_s    = i_target;
                    n_state   = ST_RUN;
                end
            end
            ST_RUN: begin
                n_p_valid = 1'b1;
                n_p_s     = r_rd_s;
                if (r_rd_s == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_rd_s = r_rd_s - 1'b1;
                end
            end
            ST_DRAIN: begin
                // the last write lands this cycle; a result waits for a free slot
                if (!r_cmd.last || out_free) begin
                    n_p_valid = 1'b0;
                    if (r_cmd.last) begin
                        emit        = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_count = n_total;
                        n_out_ovf   = n_ovf;
                        n_ovf       = 1'b0;
                    end
                    if (i_cmd_valid) begin
                        o_cmd_pop = 1'b1;
                        n_cmd     = i_cmd;
                        n_rd_s    = i_target;
                        n_state   = ST_RUN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_p_valid   <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p_valid   <= n_p_valid;
            r_ovf       <= i_restart ? 1'b0 : n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_rd_s  <= n_rd_s;
        r_p_s   <= n_p_s;
        r_total <= n_total;
        if (emit) begin
            r_out_count <= n_out_count;
            r_out_ovf   <= n_out_ovf;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_path_count = r_out_count;
    assign o_count_ovf  = r_out_ovf;

endmodule

[hw/rtl/grid_path_count_exact_sum.sv]
// Exact-sum grid path counter, top level.
// Depends on gpces_pkg, gpces_front, gpces_queue, gpces_back and gpces_ram.
//
// Counts right/down paths from the top-left to the bottom-right cell of a grid
// whose coin total equals target_sum. Cells stream in row-major order, one
// signed coin value per item; a negative value blocks the cell, a value above
// the target kills every path through it. After the last cell of a grid one
// result item leaves: a 32-bit saturating path count plus an overflow flag set
// if any partial count of that grid saturated. In the count engine each cell
// takes one line-store read/write step per partial sum (target_sum down to 0)
// and one turn-around step so the next cell sees the last write; the line
// store has a single write port. A two-item queue sits between the input
// side and the engine, and the result sits in an output register, so the
// input keeps flowing while a result waits. The line store (64 columns x 256
// sums x 32 bits) needs no clearing pass: every entry read belongs to the
// current grid. Configuration: index 0 target_sum, 1 grid_rows, 2 grid_cols
// (low 7 bits kept; zero acts as 1, above 64 acts as 64); a write to one of
// these restarts the grid at the top-left cell. Write only while idle.
module grid_path_count_exact_sum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata[7:0]: coin_value (signed)
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [gpces_pkg::COIN_W-1:0]        i_s_axis_tdata,
    // tdata[31:0]: path_count, [32]: count_overflow, [39:33]: zero
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [gpces_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gpces_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gpces_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DW = gpces_pkg::DIM_W;

    logic [gpces_pkg::TARGET_W-1:0] r_target;
    logic [DW-1:0]                  r_rows;
    logic [DW-1:0]                  r_cols;
    logic                           cfg_wr;
    logic                           restart;
    logic [gpces_pkg::ROW_W-1:0]    rows_m1;
    logic [gpces_pkg::COL_W-1:0]    cols_m1;

    logic                           q_push, q_full, q_valid, q_pop;
    gpces_pkg::t_cell_cmd           front_cmd, q_cmd;
    logic [gpces_pkg::COUNT_W-1:0]  path_count;
    logic                           count_ovf;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // register writes; an index past the list is dropped without a restart
    always_comb begin
        unique case (i_cfg_index)
            gpces_pkg::CFG_TARGET,
            gpces_pkg::CFG_ROWS,
            gpces_pkg::CFG_COLS: restart = cfg_wr;
            default:             restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_rows   <= DW'(1);
            r_cols   <= DW'(1);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                gpces_pkg::CFG_TARGET: r_target <= i_cfg_data[gpces_pkg::TARGET_W-1:0];
                gpces_pkg::CFG_ROWS:   r_rows   <= i_cfg_data[DW-1:0];
                gpces_pkg::CFG_COLS:   r_cols   <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp the grid size to 1..MAX and hand over the last index
    always_comb begin
        if (r_rows == '0) begin
            rows_m1 = '0;
        end else if (r_rows > DW'(gpces_pkg::MAX_ROWS)) begin
            rows_m1 = gpces_pkg::ROW_W'(gpces_pkg::MAX_ROWS - 1);
        end else begin
            rows_m1 = gpces_pkg::ROW_W'(r_rows - 1'b1);
        end
        if (r_cols == '0) begin
            cols_m1 = '0;
        end else if (r_cols > DW'(gpces_pkg::MAX_COLS)) begin
            cols_m1 = gpces_pkg::COL_W'(gpces_pkg::MAX_COLS - 1);
        end else begin
            cols_m1 = gpces_pkg::COL_W'(r_cols - 1'b1);
        end
    end

    gpces_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_rows_m1 (rows_m1),
        .i_cols_m1 (cols_m1),
        .i_target  (r_target),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_cmd     (front_cmd)
    );

    gpces_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    gpces_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_target     (r_target),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_path_count (path_count),
        .o_count_ovf  (count_ovf)
    );

    assign o_m_axis_tdata = {
        (gpces_pkg::OUT_DATA_W - gpces_pkg::COUNT_W - 1)'(0),
        count_ovf,
        path_count
    };

endmodule

[hw/rtl/gpces_checker.sv]
// Port-level checker for grid_path_count_exact_sum, bound to the top level.
// Depends on gpces_pkg and grid_path_count_exact_sum_defines.svh.
`include "grid_path_count_exact_sum_defines.svh"

module gpces_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [gpces_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    // a waiting result stays offered
    `GPCES_ASSERT(a_res_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result item dropped while stalled")

    // and does not change under stall
    `GPCES_ASSERT(a_res_stable, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "result item changed while stalled")

    // reset empties the output register
    `GPCES_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

    // pad bits above the overflow flag are zero
    `GPCES_ASSERT(a_pad_zero, o_m_axis_tvalid |-> o_m_axis_tdata[gpces_pkg::OUT_DATA_W-1:gpces_pkg::COUNT_W+1] == '0, "nonzero pad in result item")

endmodule

bind grid_path_count_exact_sum gpces_checker u_checker (.*);

[tb/sv/gpces_path_checker.sv]
// Path-count checker for grid_path_count_exact_sum: watches the three channels,
// keeps its own count lines and compares each result item. Depends on gpces_pkg.
module gpces_path_checker
    import gpces_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_coin_valid,
    input  logic                  i_coin_ready,
    input  logic [COIN_W-1:0]     i_coin_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_DATA_W-1:0] i_res_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_W:0] COUNT_MAX = {1'b0, {COUNT_W{1'b1}}};

    typedef struct {
        logic [COUNT_W-1:0] paths;
        logic               overflow;
    } t_path_total;

    t_path_total        expected_totals[$];
    logic [COUNT_W-1:0] count_line [MAX_COLS][MAX_SUM+1];
    int                 row_at;
    int                 col_at;
    logic               ovf_seen;
    logic [TARGET_W-1:0] target_reg;
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    int                 fails = 0;

    function automatic void restart_grid();
        row_at   = 0;
        col_at   = 0;
        ovf_seen = 1'b0;
    endfunction

    // one cell: rewrite the column's count vector from the top sum down,
    // so the upper neighbor's values at lower sums are still in place
    function automatic void count_cell(logic [COIN_W-1:0] coin);
        logic             dead;
        int               v, t, rows, cols, r, c, from;
        logic [COUNT_W:0] acc;
        t_path_total      total;
        v    = int'(coin[VAL_W-1:0]);
        t    = int'(target_reg);
        if (t > MAX_SUM) t = MAX_SUM;
        rows = int'(rows_reg);
        if (rows == 0) rows = 1;
        else if (rows > MAX_ROWS) rows = MAX_ROWS;
        cols = int'(cols_reg);
        if (cols == 0) cols = 1;
        else if (cols > MAX_COLS) cols = MAX_COLS;
        r    = (row_at >= rows) ? rows - 1 : row_at;
        c    = (col_at >= cols) ? cols - 1 : col_at;
        dead = coin[COIN_W-1] || (v > t);
        for (int s = t; s >= 0; s--) begin
            acc = '0;
            if (!dead && s >= v) begin
                from = s - v;
                if (r == 0 && c == 0) begin
                    acc = {{COUNT_W{1'b0}}, (from == 0)};
                end else begin
                    if (r > 0) acc = {1'b0, count_line[c][from]};
                    if (c > 0) acc = acc + {1'b0, count_line[c-1][from]};
                    if (acc > COUNT_MAX) begin
                        acc      = COUNT_MAX;
                        ovf_seen = 1'b1;
                    end
                end
            end
            count_line[c][s] = acc[COUNT_W-1:0];
        end
        if (r == rows - 1 && c == cols - 1) begin
            total.paths    = count_line[c][t];
            total.overflow = ovf_seen;
            expected_totals.push_back(total);
            restart_grid();
        end else if (c + 1 >= cols) begin
            col_at = 0;
            row_at = r + 1;
        end else begin
            col_at = c + 1;
            row_at = r;
        end
    endfunction

    always @(posedge i_clk) begin
        t_path_total want;
        if (!i_rst_n) begin
            target_reg = '0;
            rows_reg   = DIM_W'(1);
            cols_reg   = DIM_W'(1);
            restart_grid();
            expected_totals.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET: begin
                        target_reg = i_cfg_data[TARGET_W-1:0];
                        restart_grid();
                    end
                    CFG_ROWS: begin
                        rows_reg = i_cfg_data[DIM_W-1:0];
                        restart_grid();
                    end
                    CFG_COLS: begin
                        cols_reg = i_cfg_data[DIM_W-1:0];
                        restart_grid();
                    end
                    default: ;  // unused index, no effect
                endcase
            end
            if (i_coin_valid && i_coin_ready) count_cell(i_coin_data);
            if (i_res_valid && i_res_ready) begin
                if (expected_totals.size() == 0) begin
                    $error("result item with none expected: path_count %0d",
                           i_res_data[COUNT_W-1:0]);
                    fails++;
                end else begin
                    want = expected_totals.pop_front();
                    if (i_res_data[COUNT_W-1:0] !== want.paths) begin
                        $error("path_count mismatch: expected %0d, actual %0d",
                               want.paths, i_res_data[COUNT_W-1:0]);
                        fails++;
                    end
                    if (i_res_data[COUNT_W] !== want.overflow) begin
                        $error("count_overflow mismatch: expected %0d, actual %0d",
                               want.overflow, i_res_data[COUNT_W]);
                        fails++;
                    end
                end
            end
        end
        // registered, so readers at the next edge see this edge's updates
        o_pending    <= expected_totals.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_grid_path_count_exact_sum.sv]
// Top of the grid_path_count_exact_sum testbench: clock, reset, stimulus, verdict.
// Depends on gpces_pkg, the block itself and gpces_path_checker.
module tb_grid_path_count_exact_sum;
    import gpces_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // past the register list
    localparam int RANDOM_ITEMS = 80;
    // sized for six cells at the largest target; queue, engine and output reg hold work in flight
    localparam int DRAIN_CYCLES = 6 * (MAX_SUM + 2);
    localparam int HOLD_CYCLES  = 2000;   // long receiver stall
    localparam int IDLE_LIMIT   = 20000;  // watchdog: cycles with no item moving

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  coin_valid = 1'b0;
    logic                  coin_ready;
    logic [COIN_W-1:0]     coin_data = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [OUT_DATA_W-1:0] res_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;

    // sender-side view of the grid in progress
    int tgt_now    = 0;
    int dim_rows   = 1;
    int dim_cols   = 1;
    int cells_sent = 0;   // cells of the open grid; nonzero means a grid is half fed
    int items_sent = 0;
    bit burst_mode = 0;   // sender: no gaps for this grid
    bit hold_req   = 0;   // asks the receiver for one long stall
    int idle_cycles = 0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    grid_path_count_exact_sum dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (coin_valid),
        .o_s_axis_tready (coin_ready),
        .i_s_axis_tdata  (coin_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    gpces_path_checker path_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_coin_valid (coin_valid),
        .i_coin_ready (coin_ready),
        .i_coin_data  (coin_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // rows and cols clamp alike: zero acts as 1, MAX_ROWS == MAX_COLS
    function automatic int clamp_dim(logic [CFG_DATA_W-1:0] raw);
        int d;
        d = int'(raw[DIM_W-1:0]);
        if (d == 0) return 1;
        return (d > MAX_ROWS) ? MAX_ROWS : d;
    endfunction

    // Stop offering cells, wait for every expected result; if the last grid
    // was left half fed, the engine may still be busy on a cell with no result,
    // so give it time to go idle.
    task automatic settle();
        coin_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        if (cells_sent != 0) repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // config writes only with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        settle();
        repeat ($urandom_range(0, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET: tgt_now  = int'(val);
            CFG_ROWS:   dim_rows = clamp_dim(val);
            CFG_COLS:   dim_cols = clamp_dim(val);
            default:    return;  // ignored write keeps the grid going
        endcase
        cells_sent = 0;
    endtask

    task automatic set_grid(int target, int rows_raw, int cols_raw);
        write_reg(CFG_TARGET, target[7:0]);
        write_reg(CFG_ROWS, rows_raw[7:0]);
        write_reg(CFG_COLS, cols_raw[7:0]);
    endtask

    // valid is only dropped when a gap is drawn, never lowered and raised in one step
    task automatic send_coin(logic [COIN_W-1:0] coin);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            coin_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coin_valid <= 1'b1;
        coin_data  <= coin;
        do @(posedge clk); while (!coin_ready);
        cells_sent++;
        if (cells_sent == dim_rows * dim_cols) cells_sent = 0;
        items_sent++;
    endtask

    // random coin biased so that path sums land near the target
    task automatic send_random_coin();
        int kind, step_max;
        logic [COIN_W-1:0] coin;
        kind     = $urandom_range(0, 99);
        step_max = (tgt_now * 2) / (dim_rows + dim_cols - 1) + 1;
        if (step_max > 127) step_max = 127;
        if (kind < 6)       coin = {1'b1, 7'($urandom)};            // blocked
        else if (kind < 10) coin = {1'b0, 7'($urandom_range(0, 127))};
        else if (kind < 15) coin = 8'($urandom);
        else                coin = 8'($urandom_range(0, step_max));
        send_coin(coin);
    endtask

    // stimulus
    initial begin
        int pick, rows_raw, cols_raw, target, cells, start_items;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // reset grid: 1x1, target 0
        send_coin(8'd0);      // one path
        send_coin(8'd1);      // coin above target
        send_coin(8'h80);     // most negative: blocked
        send_coin(8'hFF);     // -1: blocked
        send_coin(8'd127);    // largest coin
        write_reg(CFG_SPARE, 8'hFF);   // ignored, grid stays 1x1 target 0
        send_coin(8'd0);
        // zero dims act as 1, then a 1x3 row to the largest target
        set_grid(255, 0, 0);
        send_coin(8'd127);
        write_reg(CFG_COLS, 8'd3);
        send_coin(8'd127);
        send_coin(8'd127);
        send_coin(8'd1);
        // 2x2: both paths hit the target
        set_grid(3, 2, 2);
        repeat (4) send_coin(8'd1);
        // blocked cell lower-left: only the right-then-down path is left
        set_grid(2, 2, 2);
        send_coin(8'd0);
        send_coin(8'd1);
        send_coin(8'hFB);
        send_coin(8'd1);
        // restart mid-grid: two cells of a 3x3, then a new target
        set_grid(4, 3, 3);
        send_coin(8'd1);
        send_coin(8'd1);
        write_reg(CFG_TARGET, 8'd2);
        send_coin(8'd2);      // back at the top-left of the 3x3

        // --- widest settings: 64 rows (raw with bit 7 set) and 64 columns ---
        set_grid(255, 8'hC0, 2);
        repeat (dim_rows * dim_cols) send_random_coin();
        set_grid(255, 1, 127);
        repeat (dim_rows * dim_cols) send_random_coin();

        // --- random grids ---
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                rows_raw = $urandom_range(1, 3);
                cols_raw = $urandom_range(1, 3);
            end else if (pick < 90) begin
                rows_raw = $urandom_range(1, 64);
                cols_raw = $urandom_range(1, 2);
            end else if (pick < 95) begin
                rows_raw = $urandom_range(1, 2);
                cols_raw = $urandom_range(1, 64);
            end else begin
                // raw values out of range: masked to 7 bits, then clamped
                rows_raw = $urandom_range(0, 255);
                cols_raw = $urandom_range(0, 3);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)      target = $urandom_range(0, 15);
            else if (pick < 60) target = $urandom_range(0, 255);
            else if (pick < 80) target = (clamp_dim(rows_raw[7:0]) + clamp_dim(cols_raw[7:0])
                                          - 1) * $urandom_range(0, 8);
            else if (pick < 90) target = 0;
            else                target = 255;
            if (target > 255) target = 255;
            set_grid(target, rows_raw, cols_raw);
            if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, 8'($urandom));
            burst_mode = ($urandom_range(0, 3) == 0);
            cells = dim_rows * dim_cols;
            // some grids are cut short and abandoned by the next config write
            if ($urandom_range(0, 99) < 8) cells = $urandom_range(0, cells - 1);
            repeat (cells) send_random_coin();
        end
        burst_mode = 0;

        // --- back-pressure: receiver stalls while 1x1 grids keep coming ---
        set_grid(0, 1, 1);
        hold_req = 1;
        repeat (12) send_coin(8'd0);
        settle();   // sender waits for every result

        // --- saturation: 18x19 zero grid, C(35,17) paths exceed 32 bits ---
        set_grid(0, 18, 19);
        burst_mode = 1;
        repeat (dim_rows * dim_cols) send_coin(8'd0);
        burst_mode = 0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side: random gaps, gap-free stretches, one long hold on request
    initial begin
        int gap, rx_count;
        bit rx_eager;
        rx_count = 0;
        rx_eager = 0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            if (rx_count % 16 == 0) rx_eager = ($urandom_range(0, 3) == 0);
            gap = rx_eager ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            rx_count++;
        end
    end

    // watchdog: any item moving on any channel resets the count
    always @(posedge clk) begin
        if ((coin_valid && coin_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[grid_path_count_exact_sum.f]
+incdir+hw/rtl
hw/rtl/gpces_pkg.sv
hw/rtl/gpces_ram.sv
hw/rtl/gpces_queue.sv
hw/rtl/gpces_front.sv
hw/rtl/gpces_back.sv
hw/rtl/grid_path_count_exact_sum.sv
hw/rtl/gpces_checker.sv
tb/sv/gpces_path_checker.sv
tb/sv/tb_grid_path_count_exact_sum.sv
